FILE: design/cslot_pkg.sv
// cslot_pkg: shared widths, codes and occupancy word geometry for the
// circular slot allocator. No dependencies.
`timescale 1ns / 1ps

package cslot_pkg;

    localparam int RING_W      = 11;    // ring_size register width
    localparam int SLOT_W      = 10;    // slot index field width
    localparam int STATUS_W    = 2;
    localparam int FIELD_LIMIT = 1024;  // slots addressable by the slot field
    localparam int WORD_W      = 64;    // occupancy bits per memory word
    localparam int WORD_LG     = 6;     // log2(WORD_W)

    localparam logic [RING_W-1:0] RING_RESET = 11'd1024;

    typedef enum logic [0:0] {
        KIND_CLAIM   = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

endpackage

FILE: design/circular_slot_allocator.sv
// Circular slot allocator top level: occupancy memory, word search sequencer
// and output register. Depends on cslot_pkg.
`timescale 1ns / 1ps

// A claim request (tuser 0) names a preferred slot; the block grants the first
// free slot at or after it, wrapping past the last slot in use, marks it taken
// and returns it with status granted, full or out of range. A release request
// (tuser 1) frees the slot and returns nothing. Occupancy is held in a
// single-port memory of 64-bit words, scanned one word at a time. Each word
// costs one registered memory read and one priority search. A result sits in
// an output register, so the next request is taken while it waits. Per-word
// valid bits make the map read as all free after reset, so no clearing pass
// is needed.
module circular_slot_allocator #(
    parameter int SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cslot_pkg::RING_W-1:0]  cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [9:0] slot
    input  logic [0:0]                    s_axis_tuser,   // [0] kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [9:0] granted_slot
    output logic [1:0]                    m_axis_tuser    // [1:0] status
);
    import cslot_pkg::*;

    localparam int CAP    = (SLOTS < FIELD_LIMIT) ? SLOTS : FIELD_LIMIT;
    localparam int WORDS  = (CAP + WORD_W - 1) / WORD_W;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [RING_W-1:0] CAP_R = RING_W'(CAP);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXAM,
        S_RREAD,
        S_RWRITE,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [RING_W-1:0]    ring_reg;
    logic [WIDX_W-1:0]    word_reg, word_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 wrap_reg, wrap_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [STATUS_W-1:0]  res_st_reg, res_st_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [STATUS_W-1:0]  out_st_reg, out_st_next;

    logic [WORD_W-1:0]    mem [0:WORDS-1];
    logic [WORDS-1:0]     vld_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;
    logic                 mem_we;
    logic [WORD_W-1:0]    mem_wdata;

    logic [RING_W-1:0]    n_c;
    logic [WIDX_W-1:0]    lw_c, sw_c;
    logic [RING_W-1:0]    base_c;
    logic [WORD_W-1:0]    word_eff;
    logic [WORD_W-1:0]    free_c;
    logic                 found_c;
    logic [WORD_LG-1:0]   pos_c;
    logic [SLOT_W-1:0]    in_slot;
    logic                 in_kind;
    logic                 accept;

    assign in_slot = s_axis_tdata[SLOT_W-1:0];
    assign in_kind = s_axis_tuser[0];
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // slots in use, clamped to 1..CAP
    always_comb
    begin
        if (ring_reg == '0)
            n_c = RING_W'(1);
        else if (ring_reg > CAP_R)
            n_c = CAP_R;
        else
            n_c = ring_reg;
    end

    assign lw_c     = WIDX_W'((n_c - RING_W'(1)) >> WORD_LG);
    assign sw_c     = WIDX_W'(slot_reg >> WORD_LG);
    assign base_c   = RING_W'(word_reg) << WORD_LG;
    assign word_eff = rd_vld_reg ? rd_data_reg : '0;

    // window of candidate bits in the current word, then first free one
    always_comb
    begin
        logic [RING_W-1:0] idx;
        logic              ok;
        logic [RING_W-1:0] s_ext;
        s_ext   = RING_W'(slot_reg);
        found_c = 1'b0;
        pos_c   = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            idx = base_c + RING_W'(b);
            ok  = (idx < n_c);
            if (word_reg == sw_c)
            begin
                if (wrap_reg)
                    ok = ok && (idx < s_ext);
                else
                    ok = ok && (idx >= s_ext);
            end
            free_c[b] = ok && !word_eff[b];
        end
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (free_c[b])
            begin
                found_c = 1'b1;
                pos_c   = WORD_LG'(b);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        slot_next      = slot_reg;
        wrap_next      = wrap_reg;
        res_slot_next  = res_slot_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_slot_next  = out_slot_reg;
        out_st_next    = out_st_reg;
        mem_we         = 1'b0;
        mem_wdata      = word_eff;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next = in_slot;
                    word_next = WIDX_W'(in_slot >> WORD_LG);
                    wrap_next = 1'b0;
                    if (RING_W'(in_slot) >= n_c)
                    begin
                        // release out of range is dropped
                        if (in_kind == KIND_CLAIM)
                        begin
                            res_slot_next = '0;
                            res_st_next   = ST_RANGE;
                            state_next    = S_DONE;
                        end
                    end
                    else if (in_kind == KIND_CLAIM)
                        state_next = S_READ;
                    else
                        state_next = S_RREAD;
                end
            end
            S_READ:
                state_next = S_EXAM;
            S_EXAM:
            begin
                if (found_c)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = word_eff | (WORD_W'(1) << pos_c);
                    res_slot_next = SLOT_W'(base_c + RING_W'(pos_c));
                    res_st_next   = ST_GRANTED;
                    state_next    = S_DONE;
                end
                else if (wrap_reg && (word_reg == sw_c))
                begin
                    res_slot_next = '0;
                    res_st_next   = ST_FULL;
                    state_next    = S_DONE;
                end
                else
                begin
                    if (word_reg == lw_c)
                    begin
                        word_next = '0;
                        wrap_next = 1'b1;
                    end
                    else
                        word_next = word_reg + WIDX_W'(1);
                    state_next = S_READ;
                end
            end
            S_RREAD:
                state_next = S_RWRITE;
            S_RWRITE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = word_eff & ~(WORD_W'(1) << slot_reg[WORD_LG-1:0]);
                state_next = S_IDLE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = res_slot_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ring_reg      <= RING_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                ring_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        slot_reg     <= slot_next;
        wrap_reg     <= wrap_next;
        res_slot_reg <= res_slot_next;
        res_st_reg   <= res_st_next;
        out_slot_reg <= out_slot_next;
        out_st_reg   <= out_st_next;
    end

    // occupancy memory, one registered read port at the current word
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[word_reg] <= mem_wdata;
        rd_data_reg <= mem[word_reg];
        rd_vld_reg  <= vld_reg[word_reg];
    end

    // a word never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (mem_we)
            vld_reg[word_reg] <= 1'b1;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_slot_reg);
    assign m_axis_tuser  = out_st_reg;

    a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined status code on result");

    a_release_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_kind == KIND_RELEASE) && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("release request produced a result");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion step");

    a_grant_hits_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXAM && found_c) |-> !word_eff[pos_c])
        else $error("grant on an occupied slot");

endmodule

FILE: tb/cslot_grant_checker.sv
`timescale 1ns / 1ps
// cslot_grant_checker: watches the config port, the request channel and the result channel of the
// circular slot allocator, keeps its own occupancy map and checks every grant.
// Depends on cslot_pkg.

module cslot_grant_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cslot_pkg::RING_W-1:0] cfg_wdata,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,
    input  logic [0:0]                   s_axis_tuser,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [15:0]                  m_axis_tdata,
    input  logic [1:0]                   m_axis_tuser,
    output int unsigned                  mismatches,
    output int unsigned                  outstanding
);
    import cslot_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } grant_t;

    logic              taken [FIELD_LIMIT];
    logic [RING_W-1:0] ring_size;
    grant_t            pending_grants [$];

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        $display("[%0t] %s: got %0d, want %0d", $time, what, got_v, want_v);
        mismatches++;
    endtask

    // Applies one request to the local map; a claim always yields a result, a release never does.
    function automatic void allocate_slot(input kind_t k, input logic [SLOT_W-1:0] s,
                                          output bit has_grant, output grant_t g);
        int unsigned live;
        int unsigned idx;
        live = (ring_size == 0) ? 1 : ((ring_size > FIELD_LIMIT) ? FIELD_LIMIT : ring_size);
        has_grant = 1'b0;
        g.slot    = '0;
        g.status  = ST_FULL;
        if (k == KIND_RELEASE)
        begin
            if (s < live)
                taken[s] = 1'b0;
            return;
        end
        has_grant = 1'b1;
        if (s >= live)
        begin
            g.status = ST_RANGE;
            return;
        end
        for (int i = 0; i < live; i++)
        begin
            idx = s + i;
            if (idx >= live)
                idx -= live;
            if (!taken[idx])
            begin
                taken[idx] = 1'b1;
                g.slot     = idx[SLOT_W-1:0];
                g.status   = ST_GRANTED;
                return;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t got;
        grant_t want;
        grant_t fresh;
        bit     has_grant;
        if (!rst_n)
        begin
            foreach (taken[i])
                taken[i] = 1'b0;
            ring_size = RING_RESET;
            pending_grants.delete();
            mismatches = 0;
        end
        else
        begin
            // results leave a register, so a grant never belongs to this edge's request
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.slot   = m_axis_tdata[SLOT_W-1:0];
                got.status = status_t'(m_axis_tuser);
                if (pending_grants.size() == 0)
                    report_mismatch("grant with no claim waiting", got.slot, 0);
                else
                begin
                    want = pending_grants.pop_front();
                    if (got.slot !== want.slot)
                        report_mismatch("granted_slot", got.slot, want.slot);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
            // a request taken at this edge still sees the old ring size
            if (s_axis_tvalid && s_axis_tready)
            begin
                allocate_slot(kind_t'(s_axis_tuser), s_axis_tdata[SLOT_W-1:0], has_grant,
                              fresh);
                if (has_grant)
                    pending_grants.push_back(fresh);
            end
            if (cfg_we)
                ring_size = cfg_wdata;
        end
        outstanding = pending_grants.size();
    end

endmodule

FILE: tb/circular_slot_allocator_tb.sv
`timescale 1ns / 1ps
// circular_slot_allocator_tb: clock, reset, request stimulus, config writes and the
// verdict for the circular slot allocator. Depends on cslot_pkg and cslot_grant_checker.

module circular_slot_allocator_tb;
    import cslot_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 60;
    localparam int STALL_LIMIT = 3000;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_we        = 1'b0;
    logic [RING_W-1:0] cfg_wdata     = '0;
    logic              s_axis_tvalid = 1'b0;
    logic [15:0]       s_axis_tdata  = '0;
    logic [0:0]        s_axis_tuser  = '0;
    logic              m_axis_tready = 1'b0;
    wire               s_axis_tready;
    wire               m_axis_tvalid;
    wire  [15:0]       m_axis_tdata;
    wire  [1:0]        m_axis_tuser;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned quiet_cycles = 0;
    int unsigned ring_live    = FIELD_LIMIT;
    bit          no_gaps          = 1'b0;
    bit          backpressure_req = 1'b0;

    circular_slot_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [9:0] slot
        .s_axis_tuser  (s_axis_tuser),   // [0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [9:0] granted_slot
        .m_axis_tuser  (m_axis_tuser)    // [1:0] status
    );

    cslot_grant_checker i_grant_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // mostly back to back, some short gaps, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input kind_t k, input int unsigned s);
        int unsigned gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= 16'(s[SLOT_W-1:0]);
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // stop offering, let every grant out, then cover a release still in flight
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_ring(input int unsigned v);
        drain_block();
        cfg_wdata <= RING_W'(v);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ring_live = (v == 0) ? 1 : ((v > FIELD_LIMIT) ? FIELD_LIMIT : v);
    endtask

    task automatic random_request();
        int unsigned r;
        int unsigned s;
        kind_t       k;
        k = ($urandom_range(0, 99) < 58) ? KIND_CLAIM : KIND_RELEASE;
        r = $urandom_range(0, 99);
        if (r < 75)
            s = $urandom_range(0, ring_live - 1);
        else if (r < 87)
            s = $urandom_range(0, FIELD_LIMIT - 1);
        else if (r < 94)
            s = ring_live - 1;
        else
            s = ring_live % FIELD_LIMIT;
        send_request(k, s);
    endtask

    // receiver: open and shut windows, plus one long hold on request
    initial
    begin
        int unsigned open_cycles;
        int unsigned shut_cycles;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (backpressure_req)
            begin
                backpressure_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                open_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                          : $urandom_range(1, 12);
                shut_cycles = pick_gap();
                m_axis_tready <= 1'b1;
                repeat (open_cycles) @(posedge clk);
                if (shut_cycles != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (shut_cycles) @(posedge clk);
                end
            end
        end
    end

    // watchdog: cycles with no request moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("circular_slot_allocator: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned ring_plan [11];
        ring_plan = '{64, 1, 2, 2047, 100, 0, 65, 3, 1024, 0, 0};
        ring_plan[9]  = $urandom_range(1, FIELD_LIMIT);
        ring_plan[10] = $urandom_range(4, 40);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ring of 1024: wrap from the top slot, release and reclaim
        send_request(KIND_CLAIM, 0);
        send_request(KIND_CLAIM, 0);
        send_request(KIND_CLAIM, 1023);
        send_request(KIND_CLAIM, 1023);
        send_request(KIND_RELEASE, 1);
        send_request(KIND_CLAIM, 0);
        send_request(KIND_RELEASE, 1023);
        send_request(KIND_RELEASE, 1023);   // already free
        send_request(KIND_CLAIM, 1023);

        // small ring: out of range on both kinds, full ring, wrap to a freed slot
        set_ring(4);
        send_request(KIND_CLAIM, 5);
        send_request(KIND_CLAIM, 4);
        send_request(KIND_RELEASE, 7);
        send_request(KIND_CLAIM, 3);
        send_request(KIND_CLAIM, 0);
        send_request(KIND_RELEASE, 2);
        send_request(KIND_CLAIM, 3);

        // zero acts as a ring of one
        set_ring(0);
        send_request(KIND_CLAIM, 0);
        send_request(KIND_CLAIM, 1);
        send_request(KIND_RELEASE, 1);

        // oversize clamps to 1024; slot 1023 kept its bit while the ring was small
        set_ring(2047);
        send_request(KIND_CLAIM, 1023);
        send_request(KIND_RELEASE, 0);
        send_request(KIND_CLAIM, 1022);

        foreach (ring_plan[p])
        begin
            set_ring(ring_plan[p]);
            if (p == 4)
            begin
                // fill the block while the receiver holds off
                no_gaps          = 1'b1;
                backpressure_req = 1'b1;
                repeat (40) send_request(KIND_CLAIM, $urandom_range(0, ring_live - 1));
                no_gaps = 1'b0;
                repeat (46) random_request();
            end
            else if (p == 8)
            begin
                no_gaps = 1'b1;
                repeat (30) random_request();
                no_gaps = 1'b0;
                repeat (56) random_request();
            end
            else
                repeat (86) random_request();
        end

        drain_block();
        if (mismatches == 0 && outstanding == 0)
            $display("circular_slot_allocator: match");
        else
            $display("circular_slot_allocator: mismatch");
        $finish;
    end

endmodule
